### hw/rtl/pwg_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic waveform generator: field widths, register indexes,
// waveform codes, the command and divider structs and the sequencer states.
// No dependencies.
package pwg_pkg;

  localparam int unsigned AMP_W      = 10;
  localparam int unsigned PER_W      = 16;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // amplitude numerator (A times scale constant) and divider dividend widths
  localparam int unsigned NUM_W   = 26;
  localparam int unsigned DIV_W   = 35;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned SCALE_W = 20;

  // divide by 100 as (num / 4) * ceil(2^29 / 25) >> 29, exact for 24-bit quarters
  localparam int unsigned         RECIP_W     = 25;
  localparam int unsigned         RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0]  RECIP_25    = 25'd21474837;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  typedef enum logic [2:0] {
    WAVE_PULSE   = 3'd0,
    WAVE_SQUARE  = 3'd1,
    WAVE_SAW     = 3'd2,
    WAVE_TRI     = 3'd3,
    WAVE_SILENCE = 3'd4
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM = 3'd0,
    CFG_FORMAT   = 3'd1,
    CFG_AMPL     = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_CYCLES   = 3'd4,
    CFG_DUTY     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PULSE,
    KIND_SAW,
    KIND_TRI,
    KIND_SILENCE
  } kind_e;

  localparam logic FMT_U8  = 1'b0;
  localparam logic FMT_S16 = 1'b1;

  // reset values of the configuration registers
  localparam logic [2:0]        RST_WAVE   = WAVE_PULSE;
  localparam logic              RST_FMT    = FMT_S16;
  localparam logic [AMP_W-1:0]  RST_AMPL   = 10'd100;
  localparam logic [PER_W-1:0]  RST_PERIOD = 16'd1;
  localparam logic [PER_W-1:0]  RST_CYCLES = 16'd0;
  localparam logic [DUTY_W-1:0] RST_DUTY   = 7'd10;

  localparam logic [DUTY_W-1:0] DUTY_SQUARE = 7'd50;
  localparam logic [DUTY_W-1:0] PCT_FULL    = 7'd100;

  // full-scale factors applied to the amplitude percent
  localparam logic [PER_W-1:0] MUL_U8_MARK  = 16'd127;
  localparam logic [PER_W-1:0] MUL_U8_SPACE = 16'd128;
  localparam logic [PER_W-1:0] MUL_S16      = 16'd32767;
  localparam logic [PER_W-1:0] MUL_U8_RAMP  = 16'd254;
  localparam logic [PER_W-1:0] MUL_S16_RAMP = 16'd65534;

  // output limits
  localparam logic [SAMPLE_W-1:0] LIM_S16 = 16'd32767;
  localparam logic [SAMPLE_W-1:0] U8_MID  = 16'd128;
  localparam logic [SAMPLE_W-1:0] U8_POS  = 16'd127;
  localparam logic [SAMPLE_W-1:0] U8_NEG  = 16'd128;

  typedef struct packed {
    logic              restart;
    kind_e             kind;
    logic              wide;
    logic [PER_W-1:0]  n;
    logic [PER_W-1:0]  nc;
    logic [DUTY_W-1:0] duty;
    logic [NUM_W-1:0]  num_mark;
    logic [NUM_W-1:0]  num_space;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [PER_W-1:0]  divisor;
    logic [DIV_W-1:0]  dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [PER_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XMOD,
    ST_NCMOD,
    ST_AMP,
    ST_MUL,
    ST_RGO,
    ST_RDIV,
    ST_OUT
  } state_e;

endpackage

### hw/rtl/periodic_waveform_generator.sv
`timescale 1ns / 1ps
// Top level of the periodic waveform generator: front end, back end and the
// sample queue. Depends on pwg_pkg, pwg_front, pwg_back and pwg_fifo.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ---------------------------------
//   input     in         push / full          restart_i
//   result    out        empty / pop          sample_o
//   config    in         cfg_valid_i / _ready cfg_index_i, cfg_data_i
//
// Operation: the back end works one item at a time; the phase and period
// reductions and the ramp division go through one shared bit-serial divider,
// and the percent scaling is a reciprocal multiply.
// Reset: asynchronous, active low; clears the queues, the sequencer, the phase
// and the configuration registers to their documented defaults.
// Stalls: a two-entry command queue takes items while the back end is busy, and
// a two-entry sample queue holds results while pop is low; the back end waits
// only when the sample queue is full.
module periodic_waveform_generator
  import pwg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  push,
  output logic                  full,
  input  logic                  restart_i,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // result items
  output logic                  empty,
  input  logic                  pop,
  output logic [SAMPLE_W-1:0]   sample_o
);

  cmd_t                cmd;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_full;
  logic                res_push;
  logic [SAMPLE_W-1:0] res_sample;

  // front end: config registers, classification, command queue
  pwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .restart_i   (restart_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  // back end: phase keeping, divisions, sample shaping
  pwg_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_sample_o (res_sample)
  );

  // finished samples wait here until popped
  pwg_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_sample),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (sample_o),
    .empty_o (empty)
  );

endmodule

### hw/rtl/pwg_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue with push/full and pop/empty sides.
// Standalone; used for commands and for finished samples.
module pwg_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/pwg_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, item intake and classification into
// commands, plus the command queue. Depends on pwg_pkg and pwg_fifo.
module pwg_front
  import pwg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  restart_i,
  output logic                  full_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cmd_t                  cmd_o,
  output logic                  cmd_empty_o,
  input  logic                  cmd_pop_i
);

  logic [2:0]        wave_q;
  logic              fmt_q;
  logic [AMP_W-1:0]  ampl_q;
  logic [PER_W-1:0]  period_q;
  logic [PER_W-1:0]  cycles_q;
  logic [DUTY_W-1:0] duty_q;
  cmd_t              cmd_new;
  logic [PER_W-1:0]  mul_mark;
  logic [PER_W-1:0]  mul_space;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= RST_WAVE;
      fmt_q    <= RST_FMT;
      ampl_q   <= RST_AMPL;
      period_q <= RST_PERIOD;
      cycles_q <= RST_CYCLES;
      duty_q   <= RST_DUTY;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WAVEFORM: wave_q   <= cfg_data_i[2:0];
        CFG_FORMAT:   fmt_q    <= cfg_data_i[0];
        CFG_AMPL:     ampl_q   <= cfg_data_i[AMP_W-1:0];
        CFG_PERIOD:   period_q <= cfg_data_i[PER_W-1:0];
        CFG_CYCLES:   cycles_q <= cfg_data_i[PER_W-1:0];
        CFG_DUTY:     duty_q   <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify: fold square into pulse, unused codes into silence, and form
  // the amplitude numerators that the back end divides by 100.
  always_comb begin
    cmd_new.restart = restart_i;
    cmd_new.wide    = (fmt_q == FMT_S16);
    cmd_new.n       = (period_q == '0) ? PER_W'(1) : period_q;
    cmd_new.nc      = cycles_q;
    cmd_new.duty    = duty_q;
    cmd_new.kind    = KIND_SILENCE;
    unique case (wave_q)
      WAVE_PULSE: begin
        cmd_new.kind = KIND_PULSE;
      end
      WAVE_SQUARE: begin
        cmd_new.kind = KIND_PULSE;
        cmd_new.duty = DUTY_SQUARE;
      end
      WAVE_SAW:     cmd_new.kind = KIND_SAW;
      WAVE_TRI:     cmd_new.kind = KIND_TRI;
      default:      cmd_new.kind = KIND_SILENCE;
    endcase

    if (cmd_new.kind == KIND_SAW || cmd_new.kind == KIND_TRI) begin
      mul_mark = cmd_new.wide ? MUL_S16_RAMP : MUL_U8_RAMP;
    end else begin
      mul_mark = cmd_new.wide ? MUL_S16 : MUL_U8_MARK;
    end
    mul_space = cmd_new.wide ? MUL_S16 : MUL_U8_SPACE;

    cmd_new.num_mark  = NUM_W'(ampl_q) * NUM_W'(mul_mark);
    cmd_new.num_space = NUM_W'(ampl_q) * NUM_W'(mul_space);
  end

  pwg_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_new),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

### hw/rtl/pwg_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// MSB-aligned with a step count. Depends on pwg_pkg.
module pwg_div
  import pwg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [PER_W-1:0]  rem_q, rem_d;
  logic [PER_W-1:0]  dvs_q, dvs_d;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      dq_d  = {dq_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

### hw/rtl/pwg_back.sv
`timescale 1ns / 1ps
// Back end: sequencer that owns the phase, drives the shared divider and
// forms each sample. Depends on pwg_pkg and pwg_div.
module pwg_back
  import pwg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output logic [SAMPLE_W-1:0] res_sample_o
);

  localparam int unsigned MarkW    = PER_W + DUTY_W;
  localparam int unsigned ProdW    = PER_W + SCALE_W;
  localparam int unsigned AmpProdW = NUM_W - 2 + RECIP_W;

  function automatic logic [SAMPLE_W-1:0] clip_mag(input logic [DIV_W-1:0] q,
                                                   input logic [SAMPLE_W-1:0] lim);
    clip_mag = (q > DIV_W'(lim)) ? lim : q[SAMPLE_W-1:0];
  endfunction

  // signed magnitude to sample code; same rule for pulse levels and ramps
  function automatic logic [SAMPLE_W-1:0] finish(input logic [DIV_W-1:0] q,
                                                 input logic neg,
                                                 input logic wide);
    logic [SAMPLE_W-1:0] m;
    m = clip_mag(q, LIM_S16);
    if (wide) begin
      finish = neg ? SAMPLE_W'(0) - m : m;
    end else if (neg) begin
      finish = U8_MID - clip_mag(q, U8_NEG);
    end else begin
      finish = U8_MID + clip_mag(q, U8_POS);
    end
  endfunction

  state_e                state_q, state_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  cmd_t                  cmd_q;
  logic [PER_W-1:0]      x_q;
  logic                  neg_q;
  logic [PER_W-1:0]      tmag_q;
  logic [SCALE_W-1:0]    scale_q;
  logic [DIV_W-1:0]      prod_q;
  logic [SAMPLE_W-1:0]   sample_q;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic [PHASE_BITS-1:0] phase_src;
  logic                  mark_c;
  logic [PER_W:0]        half;
  logic [PER_W:0]        fold;
  logic [PER_W:0]        pos;
  logic                  neg_c;
  logic [PER_W:0]        tmag_c;
  logic [PER_W:0]        sum;
  logic [PER_W:0]        wrapped;
  logic [ProdW-1:0]      prod_full;
  logic [NUM_W-1:0]      amp_num;
  logic [AmpProdW-1:0]   amp_prod;
  logic [DIV_W-1:0]      amp_quo;
  logic                  load_sample;
  logic [SAMPLE_W-1:0]   sample_d;

  assign phase_src = cmd_i.restart ? '0 : phase_q;

  // pulse mark test and signed ramp offset from the reduced phase
  always_comb begin
    mark_c = (MarkW'(x_q) * MarkW'(PCT_FULL)) < (MarkW'(cmd_q.duty) * MarkW'(cmd_q.n));
    half   = {2'b00, cmd_q.n[PER_W-1:1]};
    fold   = {x_q, 1'b0};
    if (fold > {1'b0, cmd_q.n}) begin
      fold = {cmd_q.n, 1'b0} - fold;
    end
    pos = (cmd_q.kind == KIND_TRI) ? fold : {1'b0, x_q};
    if (pos >= half) begin
      neg_c  = 1'b0;
      tmag_c = pos - half;
    end else begin
      neg_c  = 1'b1;
      tmag_c = half - pos;
    end
  end

  // amplitude numerator divided by 100 through the reciprocal
  always_comb begin
    amp_num  = (cmd_q.kind == KIND_PULSE && !mark_c) ? cmd_q.num_space : cmd_q.num_mark;
    amp_prod = AmpProdW'(amp_num[NUM_W-1:2]) * AmpProdW'(RECIP_25);
    amp_quo  = DIV_W'(amp_prod[AmpProdW-1:RECIP_SHIFT]);
  end

  // next phase: x + (nc mod n), folded once
  always_comb begin
    sum     = {1'b0, x_q} + {1'b0, div_rsp.rem};
    wrapped = (sum >= {1'b0, cmd_q.n}) ? sum - {1'b0, cmd_q.n} : sum;
    phase_d = phase_q;
    if (state_q == ST_NCMOD && div_rsp.done) begin
      phase_d = PHASE_BITS'(wrapped[PER_W-1:0]);
    end
  end

  assign prod_full = ProdW'(tmag_q) * ProdW'(scale_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!cmd_empty_i) state_d = ST_XMOD;
      ST_XMOD:  if (div_rsp.done) state_d = ST_NCMOD;
      ST_NCMOD: begin
        if (div_rsp.done) begin
          state_d = (cmd_q.kind == KIND_SILENCE) ? ST_OUT : ST_AMP;
        end
      end
      ST_AMP:   state_d = (cmd_q.kind == KIND_PULSE) ? ST_OUT : ST_MUL;
      ST_MUL:   state_d = ST_RGO;
      ST_RGO:   state_d = ST_RDIV;
      ST_RDIV:  if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:   if (!res_full_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs: queue handshakes and divider requests
  always_comb begin
    div_req    = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o        = 1'b1;
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(PHASE_BITS);
          div_req.divisor  = cmd_i.n;
          div_req.dividend = DIV_W'(phase_src) << (DIV_W - PHASE_BITS);
        end
      end
      ST_XMOD: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(PER_W);
          div_req.divisor  = cmd_q.n;
          div_req.dividend = DIV_W'(cmd_q.nc) << (DIV_W - PER_W);
        end
      end
      ST_RGO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(DIV_W);
        div_req.divisor  = cmd_q.n;
        div_req.dividend = prod_q;
      end
      ST_OUT:  res_push_o = !res_full_i;
      default: ;
    endcase
  end

  always_comb begin
    load_sample = (state_q == ST_NCMOD && div_rsp.done && cmd_q.kind == KIND_SILENCE) ||
                  (state_q == ST_AMP && cmd_q.kind == KIND_PULSE) ||
                  (state_q == ST_RDIV && div_rsp.done);
    if (cmd_q.kind == KIND_SILENCE) begin
      sample_d = cmd_q.wide ? '0 : U8_MID;
    end else begin
      sample_d = finish((state_q == ST_AMP) ? amp_quo : div_rsp.quo, neg_q, cmd_q.wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !cmd_empty_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_XMOD && div_rsp.done) begin
      x_q <= div_rsp.rem;
    end
    if (state_q == ST_NCMOD) begin
      neg_q  <= (cmd_q.kind == KIND_PULSE) ? !mark_c : neg_c;
      tmag_q <= tmag_c[PER_W-1:0];
    end
    if (state_q == ST_AMP) begin
      scale_q <= amp_quo[SCALE_W-1:0];
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[DIV_W-1:0];
    end
    if (load_sample) begin
      sample_q <= sample_d;
    end
  end

  assign res_sample_o = sample_q;

  pwg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

### hw/rtl/pwg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the periodic waveform generator, bound to the top.
// Depends on pwg_pkg.
module pwg_checker
  import pwg_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [SAMPLE_W-1:0] sample_o
);

  localparam int unsigned Capacity = CMD_DEPTH + OUT_DEPTH + 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  logic [CntW-1:0] pending_q, pending_d;
  logic            took_in, took_out;

  assign took_in  = push & ~full;
  assign took_out = pop & ~empty;

  always_comb begin
    pending_d = pending_q;
    if (took_in && !took_out) begin
      pending_d = pending_q + 1'b1;
    end else if (!took_in && took_out) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_reset_state: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not cleared in reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != '0)
    else $error("result shown with no item outstanding");

  a_full_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> pending_q >= CntW'(CMD_DEPTH))
    else $error("full raised with command queue not filled");

  a_sample_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(sample_o))
    else $error("waiting sample changed");

endmodule

bind periodic_waveform_generator pwg_checker u_pwg_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .sample_o (sample_o)
);

### tb/sv/periodic_waveform_generator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the periodic waveform generator: directed and random
// sample requests under random push/pop idling, checked against an inline model.
// Depends on pwg_pkg and periodic_waveform_generator.
module periodic_waveform_generator_test;
  import pwg_pkg::*;

  localparam int unsigned PHASE_BITS = 16;
  // slowest item (ramp) plus margin, used for the quiet tail at the end
  localparam int TAIL_CYCLES = 128;
  // several times the slowest correct run of all ~1650 items
  localparam longint TIMEOUT_NS = 64'd10_000_000;
  localparam int RANDOM_BATCHES = 40;
  localparam int BATCH_ITEMS    = 40;

  // register indexes the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  // waveform code outside the documented set, decodes to silence
  localparam logic [2:0] WAVE_SPARE = 3'd5;
  localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_ALL} idle_mode_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic restart_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SAMPLE_W-1:0] sample_o;

  // mirror of the register file and phase, as the block should hold them
  logic [2:0]            wave_sel = RST_WAVE;
  logic                  fmt_wide = RST_FMT;
  logic [AMP_W-1:0]      amp_pct  = RST_AMPL;
  logic [PER_W-1:0]      span     = RST_PERIOD;
  logic [PER_W-1:0]      cycles   = RST_CYCLES;
  logic [DUTY_W-1:0]     duty_pct = RST_DUTY;
  logic [PHASE_BITS-1:0] phase    = '0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  reg_write_t staged_writes[$];
  idle_mode_e send_mode = IDLE_ALL;
  idle_mode_e recv_mode = IDLE_ALL;
  int error_count = 0;
  int sample_count = 0;

  periodic_waveform_generator #(
    .PHASE_BITS(PHASE_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .restart_i  (restart_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .empty      (empty),
    .pop        (pop),
    .sample_o   (sample_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sample model
  // ---------------------------------------------------------------------------
  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // ramp value b -> clipped sample in the current format
  function automatic logic [SAMPLE_W-1:0] ramp_sample(input longint b);
    if (fmt_wide) return SAMPLE_W'(clamp(b, -32767, 32767));
    return SAMPLE_W'(128 + clamp(b, -128, 127));
  endfunction

  // Sample for one tick; advances the mirrored phase.
  function automatic logic [SAMPLE_W-1:0] predict_sample(input logic restart);
    longint n, x, a, d, s, duty, v, u;
    logic mark;
    logic [SAMPLE_W-1:0] result;
    n = (span == '0) ? 64'sd1 : longint'(span);   // zero period acts as one
    if (restart) phase = '0;
    x = longint'(phase) % n;                      // phase may lie outside a new span
    a = longint'(amp_pct);
    d = n / 2;
    s = fmt_wide ? (2 * a * 32767) / 100 : (2 * a * 127) / 100;
    case (wave_sel)
      WAVE_PULSE, WAVE_SQUARE: begin
        duty = (wave_sel == WAVE_SQUARE) ? 64'sd50 : longint'(duty_pct);
        mark = (x * 100) < (duty * n);           // duty above 100 is all mark
        if (fmt_wide) begin
          v = clamp((a * 32767) / 100, 0, 32767);
          result = SAMPLE_W'(mark ? v : -v);
        end else if (mark) begin
          result = SAMPLE_W'(128 + clamp((a * 127) / 100, 0, 127));
        end else begin
          result = SAMPLE_W'(128 - clamp((a * 128) / 100, 0, 128));
        end
      end
      WAVE_SAW: result = ramp_sample(((x - d) * s) / n);
      WAVE_TRI: begin
        u = 2 * x;
        if (u > n) u = 2 * n - u;
        result = ramp_sample(((u - d) * s) / n);
      end
      default: result = fmt_wide ? SAMPLE_W'(0) : U8_MID;  // silence and spare codes
    endcase
    phase = PHASE_BITS'((x + longint'(cycles) % n) % n);
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------
  function automatic int idle_cycles(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      default:   return $urandom_range(0, 17);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // One sample request; push stays high afterwards so back-to-back items
  // need no extra edge.
  task automatic send_tick(input logic restart);
    int gap;
    gap = idle_cycles(send_mode);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (full);
    pending_samples.push_back(predict_sample(restart));
  endtask

  // Stop pushing and wait until every predicted sample came out.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
  endtask

  task automatic stage(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    staged_writes.push_back('{idx: idx, data: data});
  endtask

  // Only called with the block drained.
  task automatic commit_regs();
    reg_write_t w;
    while (staged_writes.size() != 0) begin
      w = staged_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (w.idx)
        CFG_WAVEFORM: wave_sel = w.data[2:0];
        CFG_FORMAT:   fmt_wide = w.data[0];
        CFG_AMPL:     amp_pct  = w.data[AMP_W-1:0];
        CFG_PERIOD:   span     = w.data;
        CFG_CYCLES:   cycles   = w.data;
        CFG_DUTY:     duty_pct = w.data[DUTY_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Sample checker: pops with random stalls, compares with the oldest prediction.
  initial begin
    int gap;
    logic [SAMPLE_W-1:0] want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_cycles(recv_mode);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sample_count++;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %h", sample_o));
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want)
          report_mismatch($sformatf("sample %0d: got %h, want %h", sample_count,
                                    sample_o, want));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // Register defaults: pulse, 16-bit, one-sample span.
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_pulse_and_square();
    // 8-bit pulse, amplitude clipped, phase steps 0,4,8,2
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_PULSE));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_U8));
    stage(CFG_AMPL, 16'd1000);
    stage(CFG_PERIOD, 16'd10);
    stage(CFG_CYCLES, 16'd4);
    stage(CFG_DUTY, 16'd37);
    commit_regs();
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    // 16-bit square at the largest amplitude code
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_S16));
    stage(CFG_AMPL, 16'd1023);
    stage(CFG_PERIOD, 16'd7);
    stage(CFG_CYCLES, 16'd3);
    commit_regs();
    send_tick(1'b1);
    send_tick(1'b0);
    // duty field all ones: above 100, every sample is mark; zero amplitude
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_PULSE));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_U8));
    stage(CFG_AMPL, 16'd0);
    stage(CFG_DUTY, ALL_ONES);
    commit_regs();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_ramps();
    // widest span, cycles equal to span (reduces to a standing phase)
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SAW));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_S16));
    stage(CFG_AMPL, 16'd1023);
    stage(CFG_PERIOD, ALL_ONES);
    stage(CFG_CYCLES, ALL_ONES);
    commit_regs();
    send_tick(1'b1);
    send_tick(1'b0);
    // cycles far above span
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_TRI));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_U8));
    stage(CFG_AMPL, 16'd100);
    stage(CFG_PERIOD, 16'd6);
    commit_regs();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    // zero period behaves as one
    drain();
    stage(CFG_PERIOD, 16'd0);
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_S16));
    commit_regs();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_silence_codes();
    // all-ones waveform field is a spare code; spare indexes change nothing
    drain();
    stage(CFG_WAVEFORM, ALL_ONES);
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_U8));
    stage(CFG_SPARE_LO, ALL_ONES);
    stage(CFG_SPARE_HI, ALL_ONES);
    commit_regs();
    send_tick(1'b0);
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SILENCE));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_S16));
    commit_regs();
    send_tick(1'b0);
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SPARE));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_U8));
    commit_regs();
    send_tick(1'b1);
  endtask

  // Shrinking the span while running leaves the phase outside it.
  task automatic test_span_rewrite();
    drain();
    stage(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SAW));
    stage(CFG_FORMAT, CFG_DATA_W'(FMT_S16));
    stage(CFG_AMPL, 16'd100);
    stage(CFG_PERIOD, 16'd1000);
    stage(CFG_CYCLES, 16'd999);
    commit_regs();
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    stage(CFG_PERIOD, 16'd10);
    commit_regs();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // occasionally sets bits above the register width, which must be ignored
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] val,
                                                      input int width);
    if ($urandom_range(0, 7) == 0) return val | (CFG_DATA_W'($urandom) << width);
    return val;
  endfunction

  // Random subset of registers; periods mostly small, some extremes.
  task automatic randomize_settings();
    logic [PER_W-1:0] per, cyc;
    logic [AMP_W-1:0] amp;
    logic [2:0] wf;
    case ($urandom_range(0, 9))
      0:       per = PER_W'($urandom_range(0, 1));
      1:       per = PER_W'($urandom_range(0, 65535));
      2:       per = '1;
      default: per = PER_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 5))
      0:       cyc = PER_W'($urandom_range(0, 65535));
      1:       cyc = per;
      default: cyc = PER_W'($urandom_range(0, per));
    endcase
    case ($urandom_range(0, 5))
      0:       amp = '0;
      1:       amp = '1;
      2:       amp = AMP_W'($urandom_range(101, 1023));
      default: amp = AMP_W'($urandom_range(0, 100));
    endcase
    wf = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    if ($urandom_range(0, 7) != 0) stage(CFG_WAVEFORM, with_junk(CFG_DATA_W'(wf), 3));
    if ($urandom_range(0, 7) != 0)
      stage(CFG_FORMAT, with_junk(CFG_DATA_W'($urandom_range(0, 1)), 1));
    if ($urandom_range(0, 7) != 0) stage(CFG_AMPL, with_junk(CFG_DATA_W'(amp), AMP_W));
    if ($urandom_range(0, 7) != 0) stage(CFG_PERIOD, per);
    if ($urandom_range(0, 7) != 0) stage(CFG_CYCLES, cyc);
    if ($urandom_range(0, 7) != 0)
      stage(CFG_DUTY, with_junk(CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 127)
                                            : $urandom_range(0, 100)), DUTY_W));
    if ($urandom_range(0, 9) == 0)
      stage($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
  endtask

  // Batches of random ticks, each under fresh settings and idling modes.
  task automatic test_random_settings();
    for (int batch = 0; batch < RANDOM_BATCHES; batch++) begin
      drain();
      randomize_settings();
      commit_regs();
      send_mode = idle_mode_e'($urandom_range(0, 2));
      recv_mode = idle_mode_e'($urandom_range(0, 2));
      repeat (BATCH_ITEMS) send_tick($urandom_range(0, 7) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_pulse_and_square();
    test_ramps();
    test_silence_codes();
    test_span_rewrite();
    test_random_settings();
    drain();
    // any stray sample would show up within one item time
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("periodic_waveform_generator_test OK");
    end else begin
      $display("periodic_waveform_generator_test NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT: %0d samples still pending", pending_samples.size());
    $display("periodic_waveform_generator_test NOT OK");
    $finish;
  end

endmodule

### periodic_waveform_generator.f
hw/rtl/pwg_pkg.sv
hw/rtl/pwg_fifo.sv
hw/rtl/pwg_front.sv
hw/rtl/pwg_div.sv
hw/rtl/pwg_back.sv
hw/rtl/periodic_waveform_generator.sv
hw/rtl/pwg_checker.sv
tb/sv/periodic_waveform_generator_test.sv
